// ----- sv/pls_pkg.sv -----
// Package with the types and constants shared by the positional list store.
package pls_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 5;
    localparam int ENTRY_W  = 5;
    localparam int DATA_W   = 32;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [2:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_INS_POS   = 3'd2,
        OP_DEL_FRONT = 3'd3,
        OP_DEL_BACK  = 3'd4,
        OP_DEL_POS   = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_REJECT = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    typedef struct packed {
        logic              ins;
        logic              del;
        logic [IDX_W-1:0]  pos;
        logic [DATA_W-1:0] value;
    } cell_ctrl_t;

endpackage

// ----- sv/pls_cell.sv -----
// One storage cell of the list, shifting toward either neighbor on insert or delete.
module pls_cell import pls_pkg::*; (
    input  logic              aclk,
    input  cell_ctrl_t        ctrl,
    input  logic [IDX_W-1:0]  cell_idx,
    input  logic [DATA_W-1:0] left_data,
    input  logic [DATA_W-1:0] right_data,
    output logic [DATA_W-1:0] data,
    output logic [DATA_W-1:0] sel_data
);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        if (ctrl.ins) begin
            if (cell_idx == ctrl.pos) begin
                data_next = ctrl.value;
            end else if (cell_idx > ctrl.pos) begin
                data_next = left_data;
            end
        end else if (ctrl.del) begin
            if (cell_idx >= ctrl.pos) begin
                data_next = right_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    assign sel_data = (cell_idx == ctrl.pos) ? data_reg : '0;

endmodule

// ----- sv/positional_list_store.sv -----
// Top level of the positional list store: request decode, count and the row of cells.
//
// The list is held in a row of CAPACITY cells, one value per cell, with position 0 in
// the first cell. Each insert or delete (at the front, the back or a position) is
// decoded as it is accepted; if done, the cells from its position on shift together
// at that clock edge, so the block takes one transaction per cycle while results are
// taken, a rate set by the cell row's single shift step. The result is registered and
// appears on the master side in the cycle after acceptance; a new transaction is
// accepted in the same cycle the waiting result is taken. Cells beyond the count hold
// stale data that is never read; after reset the list is empty and usable at once.
module positional_list_store import pls_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [2:0]  s_tuser,  // op[2:0]
    input  logic [39:0] s_tdata,  // position[4:0], value[36:5], zero[39:37]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [1:0]  m_tuser,  // status[1:0]
    output logic [39:0] m_tdata   // removed_value[31:0], entry_count[36:32], zero[39:37]
);

    logic                out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    status_t             status_reg, status_next;
    logic [DATA_W-1:0]   removed_reg, removed_next;
    logic [ENTRY_W-1:0]  entry_reg, entry_next;

    logic                accept;
    op_t                 op;
    logic [CMP_W-1:0]    cnt_ext;
    logic [CMP_W-1:0]    pos_ext;
    logic [CMP_W-1:0]    tgt;
    logic [CMP_W-1:0]    cnt_after;
    cell_ctrl_t          ctrl;
    logic [DATA_W-1:0]   removed_sel;

    logic [DATA_W-1:0]   cell_data [CAPACITY];
    logic [DATA_W-1:0]   cell_sel  [CAPACITY];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign op       = op_t'(s_tuser);
    assign cnt_ext  = CMP_W'(count_reg);
    assign pos_ext  = CMP_W'(s_tdata[POS_W-1:0]);

    always_comb begin
        removed_sel = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            removed_sel = removed_sel | cell_sel[i];
        end
    end

    always_comb begin
        tgt         = '0;
        status_next = ST_REJECT;
        ctrl.ins    = 1'b0;
        ctrl.del    = 1'b0;
        ctrl.value  = s_tdata[POS_W +: DATA_W];
        case (op)
            OP_INS_FRONT: tgt = '0;
            OP_INS_BACK:  tgt = cnt_ext;
            OP_INS_POS:   tgt = pos_ext;
            OP_DEL_FRONT: tgt = '0;
            OP_DEL_BACK:  tgt = cnt_ext - CMP_W'(1);
            OP_DEL_POS:   tgt = pos_ext;
            default:      tgt = '0;
        endcase
        case (op)
            OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
                if (tgt > cnt_ext) begin
                    status_next = ST_REJECT;
                end else if (cnt_ext >= CMP_W'(CAPACITY)) begin
                    status_next = ST_FULL;
                end else begin
                    status_next = ST_DONE;
                    ctrl.ins    = accept;
                end
            end
            OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_POS: begin
                if (cnt_ext == '0 || tgt >= cnt_ext) begin
                    status_next = ST_REJECT;
                end else begin
                    status_next = ST_DONE;
                    ctrl.del    = accept;
                end
            end
            default: status_next = ST_REJECT;
        endcase
        ctrl.pos = tgt[IDX_W-1:0];
    end

    always_comb begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        removed_next   = removed_reg;
        cnt_after      = cnt_ext;
        if (ctrl.ins) begin
            cnt_after = cnt_ext + CMP_W'(1);
        end else if (ctrl.del) begin
            cnt_after = cnt_ext - CMP_W'(1);
        end
        entry_next = cnt_after[ENTRY_W-1:0];
        if (accept) begin
            count_next     = cnt_after[CNT_W-1:0];
            out_valid_next = 1'b1;
            removed_next   = ctrl.del ? removed_sel : '0;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg  <= status_next;
            removed_reg <= removed_next;
            entry_reg   <= entry_next;
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_W-1:0] left_in;
        logic [DATA_W-1:0] right_in;

        if (g == 0) begin : g_first
            assign left_in = '0;
        end else begin : g_mid
            assign left_in = cell_data[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_in = '0;
        end else begin : g_inner
            assign right_in = cell_data[g+1];
        end

        pls_cell u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .cell_idx   (IDX_W'(g)),
            .left_data  (left_in),
            .right_data (right_in),
            .data       (cell_data[g]),
            .sel_data   (cell_sel[g])
        );
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {3'b000, entry_reg, removed_reg};

endmodule
